// ===== rtl/kphr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kphr_pkg: shared types and constants of the key scanner
// Holds the action and event codes, the register indexes, the field widths
// and the command that the top level hands to each key lane.
// ----------------------------------------------------------------------------
package kphr_pkg;

    localparam int unsigned ACTION_W  = 2;
    localparam int unsigned PINS_W    = 4;
    localparam int unsigned CHANNEL_W = 2;
    localparam int unsigned MSG_W     = 8;
    localparam int unsigned STEP_W    = 8;
    localparam int unsigned TIME_W    = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned MSG_KEYS  = MSG_W / 2;

    localparam logic [STEP_W-1:0] HOLD_STEP_RST  = 8'd10;
    localparam logic [TIME_W-1:0] HOLD_LIMIT_RST = 16'd1000;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK   = 2'd0,
        ACT_READ   = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_UNUSED = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        EV_IDLE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_HOLD    = 2'd2,
        EV_RELEASE = 2'd3
    } t_event;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_STEP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT = 1'd1;

    typedef struct packed {
        logic tick;
        logic read;
        logic clear;
        logic level;
    } t_lane_cmd;

endpackage
`default_nettype wire

// ===== rtl/kphr_key.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kphr_key: state and event logic of one key
// Keeps the previous level, the pending event and the hold time of one key,
// updates them on a tick, read or clear, and gives the event bits of a read.
// ----------------------------------------------------------------------------
module kphr_key (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire  kphr_pkg::t_lane_cmd        i_cmd,
    input  wire  [kphr_pkg::STEP_W-1:0]      i_hold_step,
    input  wire  [kphr_pkg::TIME_W-1:0]      i_hold_limit,
    output logic [1:0]                       o_bits
);

    logic                            r_prev;
    kphr_pkg::t_event                r_event;
    logic [kphr_pkg::TIME_W-1:0]     r_time;
    logic                            n_prev;
    kphr_pkg::t_event                n_event;
    logic [kphr_pkg::TIME_W-1:0]     n_time;
    logic [kphr_pkg::TIME_W:0]       sum;

    always_comb begin
        sum     = {1'b0, r_time} + (kphr_pkg::TIME_W + 1)'(i_hold_step);
        n_prev  = r_prev;
        n_event = r_event;
        n_time  = r_time;
        o_bits  = 2'd0;
        if (i_cmd.tick) begin
            n_prev = i_cmd.level;
            if (!r_prev && i_cmd.level) begin
                n_event = kphr_pkg::EV_PRESS;
            end else if (r_prev && i_cmd.level) begin
                n_event = kphr_pkg::EV_HOLD;
                n_time  = sum[kphr_pkg::TIME_W] ? '1 : sum[kphr_pkg::TIME_W-1:0];
            end else if (r_prev && !i_cmd.level) begin
                n_event = kphr_pkg::EV_RELEASE;
                n_time  = '0;
            end else begin
                n_event = kphr_pkg::EV_IDLE;
            end
        end else if (i_cmd.read) begin
            if (r_event == kphr_pkg::EV_PRESS || r_event == kphr_pkg::EV_RELEASE) begin
                o_bits  = r_event;
                n_event = kphr_pkg::EV_IDLE;
            end else if (r_event == kphr_pkg::EV_HOLD && r_time > i_hold_limit) begin
                o_bits = r_event;
                n_time = i_hold_limit;
            end
        end else if (i_cmd.clear) begin
            n_time = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 1'b0;
            r_event <= kphr_pkg::EV_IDLE;
            r_time  <= '0;
        end else begin
            r_prev  <= n_prev;
            r_event <= n_event;
            r_time  <= n_time;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/key_press_hold_release_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// key_press_hold_release_scan: press, hold and release scanner for push keys
// Items arrive on the slave stream: a sample tick with the active-low pin
// levels, a read of the event message, or a clear of one key's hold time.
// Every item gives exactly one result item on the master stream, carrying
// the 8-bit message (two bits per key, zero unless the item was a read).
// An accepted item waits in the input register; the key lanes then update
// their state and load the result register as the item moves on, and the
// result is offered from there until the receiver takes it.
// One item is taken every cycle while the receiver keeps taking results: all
// keys are handled side by side by small adders and compares, and the input
// register moves on whenever the result register is empty or being taken.
// When the receiver stalls, the result holds, then the input register fills
// and the slave ready falls until the result is taken.
// The configuration channel is always ready and writes hold_step (index 0)
// and hold_limit (index 1); write it only while the block is idle.
// Reset restores the step to 10, the limit to 1000 and every key to idle
// with no hold time, and empties both registers.
// ----------------------------------------------------------------------------
module key_press_hold_release_scan #(
    parameter int unsigned KEYS = 4
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    // action [1:0], key_pins [5:2], channel [7:6]
    input  wire  [7:0]                           i_s_tdata,
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    // message [7:0]
    output logic [7:0]                           o_m_tdata,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [kphr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [kphr_pkg::CFG_DAT_W-1:0]       i_cfg_data
);

    localparam int unsigned PIN_KEYS = kphr_pkg::PINS_W;

    logic                                r_in_valid;
    kphr_pkg::t_action                   r_action;
    logic [kphr_pkg::PINS_W-1:0]         r_pins;
    logic [kphr_pkg::CHANNEL_W-1:0]      r_channel;
    logic                                r_out_valid;
    logic [kphr_pkg::MSG_W-1:0]          r_msg;
    logic [kphr_pkg::MSG_W-1:0]          n_msg;
    logic [kphr_pkg::STEP_W-1:0]         r_hold_step;
    logic [kphr_pkg::TIME_W-1:0]         r_hold_limit;
    logic                                advance;
    logic                                s_accept;
    logic [1:0]                          lane_bits [KEYS];

    assign advance     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || advance;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_msg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_step  <= kphr_pkg::HOLD_STEP_RST;
            r_hold_limit <= kphr_pkg::HOLD_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                kphr_pkg::REG_HOLD_STEP: begin
                    r_hold_step <= i_cfg_data[kphr_pkg::STEP_W-1:0];
                end
                kphr_pkg::REG_HOLD_LIMIT: begin
                    r_hold_limit <= i_cfg_data[kphr_pkg::TIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_action  <= kphr_pkg::t_action'(i_s_tdata[1:0]);
            r_pins    <= i_s_tdata[5:2];
            r_channel <= i_s_tdata[7:6];
        end
    end

    for (genvar I = 0; I < KEYS; I++) begin : g_key
        kphr_pkg::t_lane_cmd cmd;

        always_comb begin
            cmd.tick  = advance && (r_action == kphr_pkg::ACT_TICK);
            cmd.read  = advance && (r_action == kphr_pkg::ACT_READ);
            cmd.clear = 1'b0;
            cmd.level = 1'b0;
            if (I < PIN_KEYS) begin
                cmd.level = ~r_pins[I % PIN_KEYS];
                cmd.clear = advance && (r_action == kphr_pkg::ACT_CLEAR)
                            && (r_channel == kphr_pkg::CHANNEL_W'(I % PIN_KEYS));
            end
        end

        kphr_key u_key (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_hold_step  (r_hold_step),
            .i_hold_limit (r_hold_limit),
            .o_bits       (lane_bits[I])
        );
    end

    always_comb begin
        n_msg = '0;
        for (int i = 0; i < KEYS; i++) begin
            if (i < kphr_pkg::MSG_KEYS) begin
                n_msg[2*i +: 2] = lane_bits[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_msg <= n_msg;
        end
    end

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("item left the input register without a result");

    a_message_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_action != kphr_pkg::ACT_READ) |=> r_msg == '0)
        else $error("nonzero message for an item that is not a read");

    a_limit_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && (i_cfg_index == kphr_pkg::REG_HOLD_LIMIT)
        |=> r_hold_limit == $past(i_cfg_data[kphr_pkg::TIME_W-1:0]))
        else $error("hold limit write lost");

    a_full_input_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_m_tready |-> !o_s_tready)
        else $error("input taken while both registers are held");

endmodule
`default_nettype wire

// ===== dv/key_press_hold_release_scan_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_press_hold_release_scan_test: self-checking bench for the key scanner
// Drives ticks, reads, clears and unused actions on the slave stream and
// rewrites hold_step and hold_limit between phases. A predictor in the bench
// tracks every key's level, event and hold time, and each result on the
// master stream is checked against the oldest predicted message. Both sides
// idle at random, and the receiver also holds off long enough to stall the
// input.
// ----------------------------------------------------------------------------
module key_press_hold_release_scan_test;

    import kphr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 100000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [7:0]           o_m_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    key_press_hold_release_scan #(
        .KEYS(4)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Scanner state as the bench expects it.
    logic [3:0]        bench_level;
    t_event            key_ev [4];
    logic [TIME_W-1:0] hold_tm [4];
    logic [STEP_W-1:0] step_cfg;
    logic [TIME_W-1:0] limit_cfg;

    logic [7:0] msg_q [$];

    bit idle_en;
    int long_stall;
    int items_sent;
    int results_seen;
    int mismatches;
    int errors;
    int cfg_writes;
    int press_seen;
    int hold_seen;
    int release_seen;
    int unsigned cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles with %0d results outstanding.",
                         cycles, msg_q.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic logic [7:0] predict_message(t_action act, logic [3:0] pins,
                                                   logic [1:0] ch);
        logic [3:0]  lvl;
        logic [16:0] sum;
        logic [7:0]  msg;
        int          k;
        msg = '0;
        lvl = ~pins;
        case (act)
            ACT_TICK: begin
                for (k = 0; k < 4; k++) begin
                    if (!bench_level[k] && lvl[k]) begin
                        key_ev[k] = EV_PRESS;
                    end else if (bench_level[k] && lvl[k]) begin
                        sum = {1'b0, hold_tm[k]} + {9'd0, step_cfg};
                        key_ev[k] = EV_HOLD;
                        hold_tm[k] = sum[16] ? 16'hFFFF : sum[15:0];
                    end else if (bench_level[k] && !lvl[k]) begin
                        key_ev[k] = EV_RELEASE;
                        hold_tm[k] = '0;
                    end else begin
                        key_ev[k] = EV_IDLE;
                    end
                end
                bench_level = lvl;
            end
            ACT_READ: begin
                for (k = 0; k < 4; k++) begin
                    if (key_ev[k] == EV_PRESS || key_ev[k] == EV_RELEASE) begin
                        msg[2*k +: 2] = key_ev[k];
                        key_ev[k] = EV_IDLE;
                    end else if (key_ev[k] == EV_HOLD && hold_tm[k] > limit_cfg) begin
                        msg[2*k +: 2] = EV_HOLD;
                        hold_tm[k] = limit_cfg;
                    end
                end
            end
            ACT_CLEAR: begin
                hold_tm[ch] = '0;
            end
            default: begin
            end
        endcase
        return msg;
    endfunction

    task automatic send_item(t_action act, logic [3:0] pins, logic [1:0] ch);
        logic [7:0] msg;
        int         k;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {ch, pins, act};
        do @(posedge i_clk); while (!o_s_tready);
        msg = predict_message(act, pins, ch);
        for (k = 0; k < 4; k++) begin
            case (t_event'(msg[2*k +: 2]))
                EV_PRESS:   press_seen++;
                EV_HOLD:    hold_seen++;
                EV_RELEASE: release_seen++;
                default: begin
                end
            endcase
        end
        msg_q.push_back(msg);
        items_sent++;
    endtask

    // Stops offering items and waits until every predicted result has come.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (msg_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_HOLD_STEP) begin
            step_cfg = data[STEP_W-1:0];
        end else begin
            limit_cfg = data;
        end
        cfg_writes++;
    endtask

    initial begin
        i_m_tready <= 1'b1;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_stall > 0) begin
                i_m_tready <= 1'b0;
                long_stall--;
                @(posedge i_clk);
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [7:0] want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (msg_q.size() == 0) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Unexpected result item: message 0x%02h", o_m_tdata);
                    end
                end else begin
                    want = msg_q.pop_front();
                    if (o_m_tdata !== want) begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Result %0d: message expected 0x%02h, got 0x%02h",
                                     results_seen, want, o_m_tdata);
                        end
                    end
                end
            end
        end
    end

    task automatic test_directed();
        int k;
        send_item(ACT_READ, 4'hF, 2'd0);
        send_item(ACT_TICK, 4'hF, 2'd3);
        send_item(ACT_UNUSED, 4'h0, 2'd3);
        send_item(ACT_TICK, 4'h0, 2'd0);
        send_item(ACT_READ, 4'h0, 2'd3);
        send_item(ACT_READ, 4'hF, 2'd0);
        send_item(ACT_TICK, 4'h0, 2'd1);
        send_item(ACT_READ, 4'h5, 2'd2);
        send_item(ACT_TICK, 4'hA, 2'd0);
        send_item(ACT_READ, 4'h0, 2'd0);
        send_item(ACT_TICK, 4'hF, 2'd0);
        send_item(ACT_UNUSED, 4'hF, 2'd0);
        send_item(ACT_READ, 4'h0, 2'd0);
        for (k = 0; k < 4; k++) begin
            send_item(ACT_CLEAR, 4'(k * 5), 2'(k));
        end
        write_reg(REG_HOLD_STEP, 16'd255);
        write_reg(REG_HOLD_LIMIT, 16'd1);
        send_item(ACT_TICK, 4'h6, 2'd0);
        send_item(ACT_TICK, 4'h6, 2'd0);
        send_item(ACT_READ, 4'h0, 2'd0);
        send_item(ACT_READ, 4'h0, 2'd0);
        send_item(ACT_TICK, 4'h6, 2'd0);
        send_item(ACT_CLEAR, 4'h0, 2'd0);
        send_item(ACT_READ, 4'h0, 2'd0);
        send_item(ACT_TICK, 4'hF, 2'd0);
        send_item(ACT_READ, 4'h0, 2'd0);
    endtask

    task automatic test_saturation();
        write_reg(REG_HOLD_LIMIT, 16'd65534);
        repeat (259) send_item(ACT_TICK, 4'h7, 2'($urandom));
        send_item(ACT_READ, 4'h0, 2'd0);
        send_item(ACT_TICK, 4'h7, 2'd0);
        send_item(ACT_READ, 4'h0, 2'd0);
        write_reg(REG_HOLD_LIMIT, 16'hFFFF);
        send_item(ACT_TICK, 4'h7, 2'd0);
        send_item(ACT_READ, 4'h0, 2'd0);
        send_item(ACT_CLEAR, 4'h0, 2'd3);
        send_item(ACT_READ, 4'h0, 2'd0);
        // The upper data bits fall outside the step register, leaving a step of zero.
        write_reg(REG_HOLD_STEP, 16'hFF00);
        write_reg(REG_HOLD_LIMIT, 16'd0);
        send_item(ACT_TICK, 4'h7, 2'd0);
        send_item(ACT_TICK, 4'h7, 2'd0);
        send_item(ACT_READ, 4'h0, 2'd0);
        send_item(ACT_TICK, 4'hF, 2'd0);
        send_item(ACT_READ, 4'h0, 2'd0);
    endtask

    task automatic test_backpressure();
        bit saved;
        saved   = idle_en;
        idle_en = 1'b0;
        long_stall = 60;
        repeat (30) send_item(t_action'($urandom_range(0, 3)), 4'($urandom), 2'($urandom));
        drain_results();
        idle_en = saved;
    endtask

    task automatic run_key_traffic(int n_items);
        logic [3:0] down;
        int         r;
        int         k;
        down = '0;
        repeat (n_items) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                for (k = 0; k < 4; k++) begin
                    if ($urandom_range(0, 4) == 0) down[k] = ~down[k];
                end
                send_item(ACT_TICK, ~down, 2'($urandom));
            end else if (r < 80) begin
                send_item(ACT_READ, 4'($urandom), 2'($urandom));
            end else if (r < 91) begin
                send_item(ACT_CLEAR, 4'($urandom), 2'($urandom));
            end else if (r < 95) begin
                send_item(ACT_UNUSED, 4'($urandom), 2'($urandom));
            end else begin
                down = 4'($urandom);
                send_item(ACT_TICK, ~down, 2'($urandom));
            end
        end
    endtask

    task automatic test_random();
        write_reg(REG_HOLD_STEP, 16'd1);
        write_reg(REG_HOLD_LIMIT, 16'd1);
        run_key_traffic(25);
        write_reg(REG_HOLD_STEP, 16'd255);
        write_reg(REG_HOLD_LIMIT, 16'd700);
        run_key_traffic(25);
        repeat (2) begin
            write_reg(REG_HOLD_STEP, 16'($urandom_range(1, 255)));
            write_reg(REG_HOLD_LIMIT, 16'($urandom_range(1, 3000)));
            run_key_traffic(25);
        end
        idle_en = 1'b0;
        write_reg(REG_HOLD_STEP, 16'd10);
        write_reg(REG_HOLD_LIMIT, 16'd30);
        run_key_traffic(25);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        bench_level = '0;
        step_cfg  = HOLD_STEP_RST;
        limit_cfg = HOLD_LIMIT_RST;
        for (int k = 0; k < 4; k++) begin
            key_ev[k]  = EV_IDLE;
            hold_tm[k] = '0;
        end
        idle_en      = 1'b1;
        long_stall   = 0;
        items_sent   = 0;
        results_seen = 0;
        mismatches   = 0;
        errors       = 0;
        cfg_writes   = 0;
        press_seen   = 0;
        hold_seen    = 0;
        release_seen = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_saturation();
        test_backpressure();
        test_random();
        drain_results();
        repeat (8) @(posedge i_clk);

        if (msg_q.size() != 0) begin
            errors++;
        end
        $display("Sent %0d items, checked %0d results, %0d register writes.",
                 items_sent, results_seen, cfg_writes);
        $display("Reported events: %0d press, %0d hold, %0d release; %0d mismatches.",
                 press_seen, hold_seen, release_seen, mismatches);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
